FILE: hdl/qsla_pkg.sv
// Package: shared types and constants of the sieve log accumulator.
package qsla_pkg;

   localparam int SIEVE_DEPTH_DEFAULT = 65536;

   localparam int PRIME_W  = 24;
   localparam int CELL_W   = 16;
   localparam int RED_W    = 49;
   localparam int RED_CNT_W = 6;
   localparam int POS_W    = 25;
   localparam int REQ_W    = 120;
   localparam int RSP_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   typedef enum logic [1:0] {
      CMD_ADD_TWO  = 2'd0,
      CMD_ADD_ONE  = 2'd1,
      CMD_CHECK    = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_HALF   = 2'd0,
      REG_LENGTH = 2'd1,
      REG_BONUS  = 2'd2,
      REG_BOUND  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic               start;
      logic [RED_W-1:0]   value;
      logic [PRIME_W-1:0] modulus;
   } mod_req_type;

   typedef struct packed {
      logic               done;
      logic [PRIME_W-1:0] result;
   } mod_rsp_type;

endpackage

FILE: hdl/quadratic_sieve_log_accumulator_unit.sv
// Top level: sequencer of the quadratic sieve log accumulator.
// After reset the block clears all SIEVE_DEPTH cells, one per cycle, and is not
// ready for words until that pass ends (configuration writes are taken anytime).
// A check word waits while an earlier hit still waits at the output. An add walks
// each root through the cells below the active length in steps of the prime; a
// single-root add uses one reduction and a two-root add uses two.
// The roots come from one shared bit-serial reducer that
// spends 49 bit steps and a hand-over of the result on each reduction,
// and each visited cell costs a read and a write on the single memory port.
// An add with a zero prime, a check outside the active length or a reserved
// command is taken and dropped without touching the cells.
module quadratic_sieve_log_accumulator_unit #(
   parameter int SIEVE_DEPTH = qsla_pkg::SIEVE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // prime[23:0], prime_log[31:24], root_residue[55:32], a_inverse[79:56],
   // root_offset[103:80], cell_index[119:104]
   input  logic [qsla_pkg::REQ_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // offset[15:0], log_sum[31:16]
   output logic [qsla_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qsla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qsla_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam int AW = $clog2(SIEVE_DEPTH);
   localparam logic [16:0] LIM_CAP = (SIEVE_DEPTH > 65536) ? 17'd65536 : 17'(SIEVE_DEPTH);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_CLEAR   = 12'b000000000010,
      ST_MUL     = 12'b000000000100,
      ST_RED1    = 12'b000000001000,
      ST_WAIT1   = 12'b000000010000,
      ST_RED2    = 12'b000000100000,
      ST_WAIT2   = 12'b000001000000,
      ST_ROOT2   = 12'b000010000000,
      ST_WALK_RD = 12'b000100000000,
      ST_WALK_WR = 12'b001000000000,
      ST_CHK_RD  = 12'b010000000000,
      ST_CHK_WR  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [14:0] half_ff;
   logic [15:0] length_ff;
   logic [15:0] bonus_ff;
   logic [16:0] bound_ff;

   qsla_pkg::cmd_type            cmd_ff, cmd_in;
   logic [qsla_pkg::PRIME_W-1:0] p_ff, p_in;
   logic [7:0]                   w_ff, w_in;
   logic [qsla_pkg::PRIME_W-1:0] res_ff, res_in;
   logic [qsla_pkg::PRIME_W-1:0] inv_ff, inv_in;
   logic [qsla_pkg::PRIME_W-1:0] off_ff, off_in;
   logic [15:0]                  idx_ff, idx_in;
   logic [qsla_pkg::RED_W-1:0]   prod_ff, prod_in;
   logic [qsla_pkg::PRIME_W-1:0] r1_ff, r1_in;
   logic [qsla_pkg::PRIME_W-1:0] r2_ff, r2_in;
   logic [qsla_pkg::PRIME_W-1:0] offm_ff, offm_in;
   logic [qsla_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         second_ff, second_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [qsla_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [16:0]                  lim;
   logic [qsla_pkg::POS_W-1:0]   sum2;
   logic [16:0]                  total;
   logic [qsla_pkg::POS_W-1:0]   idx_wide;

   qsla_pkg::mod_req_type mreq;
   qsla_pkg::mod_rsp_type mrsp;

   logic                        ram_wr, ram_rd;
   logic [AW-1:0]               ram_addr;
   logic [qsla_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= 15'd16384;
         length_ff <= 16'd32769;
         bonus_ff  <= '0;
         bound_ff  <= '0;
      end else if (csr_valid) begin
         unique case (qsla_pkg::reg_index_type'(csr_index))
            qsla_pkg::REG_HALF:   half_ff   <= csr_data[14:0];
            qsla_pkg::REG_LENGTH: length_ff <= csr_data[15:0];
            qsla_pkg::REG_BONUS:  bonus_ff  <= csr_data[15:0];
            qsla_pkg::REG_BOUND:  bound_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign lim      = ({1'b0, length_ff} > LIM_CAP) ? LIM_CAP : {1'b0, length_ff};
   assign idx_wide = {{(qsla_pkg::POS_W-16){1'b0}}, idx_ff};
   assign sum2     = {1'b0, r1_ff} + {1'b0, p_ff} - {1'b0, offm_ff};
   assign total    = {1'b0, ram_rdata} + {1'b0, bonus_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      p_in         = p_ff;
      w_in         = w_ff;
      res_in       = res_ff;
      inv_in       = inv_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      offm_in      = offm_ff;
      pos_in       = pos_ff;
      second_in    = second_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mreq.start   = 1'b0;
      mreq.value   = prod_ff;
      mreq.modulus = p_ff;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      ram_addr     = pos_ff[AW-1:0];
      ram_wdata    = ram_rdata + {8'd0, w_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(SIEVE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = qsla_pkg::cmd_type'(req_tuser);
               p_in      = req_tdata[23:0];
               w_in      = req_tdata[31:24];
               res_in    = req_tdata[55:32];
               inv_in    = req_tdata[79:56];
               off_in    = req_tdata[103:80];
               idx_in    = req_tdata[119:104];
               second_in = 1'b0;
               case (qsla_pkg::cmd_type'(req_tuser))
                  qsla_pkg::CMD_ADD_TWO, qsla_pkg::CMD_ADD_ONE: begin
                     if (req_tdata[23:0] != '0) begin
                        state_in = ST_MUL;
                     end
                  end
                  qsla_pkg::CMD_CHECK: begin
                     if ({1'b0, req_tdata[119:104]} < lim) begin
                        state_in = ST_CHK_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (cmd_ff == qsla_pkg::CMD_ADD_TWO) begin
               prod_in = qsla_pkg::RED_W'(48'(res_ff) * 48'(inv_ff)) +
                         qsla_pkg::RED_W'(half_ff);
            end else begin
               prod_in = qsla_pkg::RED_W'(res_ff) + qsla_pkg::RED_W'(half_ff);
            end
            state_in = ST_RED1;
         end
         ST_RED1: begin
            mreq.start = 1'b1;
            state_in   = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (mrsp.done) begin
               r1_in = mrsp.result;
               if (cmd_ff == qsla_pkg::CMD_ADD_TWO) begin
                  state_in = ST_RED2;
               end else begin
                  pos_in   = {1'b0, mrsp.result};
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_RED2: begin
            mreq.start = 1'b1;
            mreq.value = qsla_pkg::RED_W'(off_ff);
            state_in   = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (mrsp.done) begin
               offm_in  = mrsp.result;
               state_in = ST_ROOT2;
            end
         end
         ST_ROOT2: begin
            if (sum2 >= {1'b0, p_ff}) begin
               r2_in = qsla_pkg::PRIME_W'(sum2 - {1'b0, p_ff});
            end else begin
               r2_in = sum2[qsla_pkg::PRIME_W-1:0];
            end
            pos_in   = {1'b0, r1_ff};
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            if (pos_ff >= qsla_pkg::POS_W'(lim)) begin
               if (cmd_ff == qsla_pkg::CMD_ADD_TWO && !second_ff) begin
                  pos_in    = {1'b0, r2_ff};
                  second_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               ram_rd   = 1'b1;
               state_in = ST_WALK_WR;
            end
         end
         ST_WALK_WR: begin
            ram_wr   = 1'b1;
            pos_in   = pos_ff + {1'b0, p_ff};
            state_in = ST_WALK_RD;
         end
         ST_CHK_RD: begin
            ram_rd   = 1'b1;
            ram_addr = idx_wide[AW-1:0];
            state_in = ST_CHK_WR;
         end
         ST_CHK_WR: begin
            ram_addr  = idx_wide[AW-1:0];
            ram_wdata = '0;
            if (!rsp_valid_ff || rsp_tready) begin
               ram_wr   = 1'b1;
               state_in = ST_IDLE;
               if (total >= bound_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {ram_rdata, idx_ff - {1'b0, half_ff}};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      cmd_ff      <= cmd_in;
      p_ff        <= p_in;
      w_ff        <= w_in;
      res_ff      <= res_in;
      inv_ff      <= inv_in;
      off_ff      <= off_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      offm_ff     <= offm_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   qsla_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   qsla_cell_ram #(
      .SIEVE_DEPTH (SIEVE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

endmodule

FILE: hdl/qsla_mod_unit.sv
// Bit-serial restoring reducer: value mod modulus, one bit per cycle.
module qsla_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  qsla_pkg::mod_req_type req,
   output qsla_pkg::mod_rsp_type rsp
);

   logic [qsla_pkg::RED_W-1:0]     val_ff, val_in;
   logic [qsla_pkg::PRIME_W-1:0]   rem_ff, rem_in;
   logic [qsla_pkg::PRIME_W-1:0]   mod_ff, mod_in;
   logic [qsla_pkg::RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [qsla_pkg::PRIME_W:0]     trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, val_ff[qsla_pkg::RED_W-1]};
      if (req.start) begin
         val_in  = req.value;
         rem_in  = '0;
         mod_in  = req.modulus;
         cnt_in  = qsla_pkg::RED_CNT_W'(qsla_pkg::RED_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, mod_ff}) begin
            rem_in = qsla_pkg::PRIME_W'(trial - {1'b0, mod_ff});
         end else begin
            rem_in = trial[qsla_pkg::PRIME_W-1:0];
         end
         val_in = {val_ff[qsla_pkg::RED_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == qsla_pkg::RED_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = rem_ff;

endmodule

FILE: hdl/qsla_cell_ram.sv
// Sieve cell memory: one port, registered read data.
module qsla_cell_ram #(
   parameter int SIEVE_DEPTH = qsla_pkg::SIEVE_DEPTH_DEFAULT,
   localparam int AW = $clog2(SIEVE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [AW-1:0]               addr,
   input  logic [qsla_pkg::CELL_W-1:0] wr_data,
   output logic [qsla_pkg::CELL_W-1:0] rd_data
);

   logic [qsla_pkg::CELL_W-1:0] mem [SIEVE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

FILE: hdl/qsla_checker.sv
// Port checker for the sieve log accumulator, bound to the top level.
module qsla_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [1:0]                 req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [qsla_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       csr_ready
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

   a_no_result_from_add: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != qsla_pkg::CMD_CHECK |=> !$rose(rsp_tvalid))
      else $error("result raised by a non-check word");

endmodule

bind quadratic_sieve_log_accumulator_unit qsla_checker u_checker (.*);
